// ===== rtl/core/todpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-of-day plan lookup package
// Sizes, function codes, entry layouts and sequencer states shared by the
// plan lookup block.
// ----------------------------------------------------------------------------
package todpl_pkg;

  localparam int SCHEDULE_SLOTS   = 64;
  localparam int PLAN_TABLES      = 16;
  localparam int PERIODS_PER_PLAN = 64;

  localparam int PERIOD_DEPTH = PLAN_TABLES * PERIODS_PER_PLAN;
  localparam int SLOT_W  = (SCHEDULE_SLOTS > 1) ? $clog2(SCHEDULE_SLOTS) : 1;
  localparam int PADDR_W = (PERIOD_DEPTH > 1) ? $clog2(PERIOD_DEPTH) : 1;

  localparam int SCAN_MAX = (SCHEDULE_SLOTS > PERIODS_PER_PLAN) ?
                            SCHEDULE_SLOTS : PERIODS_PER_PLAN;
  localparam int CNT_W    = $clog2(SCAN_MAX + 1);

  localparam int CLR_DEPTH = (SCHEDULE_SLOTS > PERIOD_DEPTH) ? SCHEDULE_SLOTS : PERIOD_DEPTH;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

  localparam logic [1:0] FUNC_QUERY     = 2'd0;
  localparam logic [1:0] FUNC_WR_SCHED  = 2'd1;
  localparam logic [1:0] FUNC_WR_PERIOD = 2'd2;

  localparam logic [2:0] SUNDAY_BIT = 3'd7;

  typedef struct packed {
    logic [4:0]  plan_number;
    logic [7:0]  week_mask;
    logic [31:0] day_mask;
    logic [12:0] month_mask;
  } sched_entry_t;

  typedef struct packed {
    logic [7:0]  action_code;
    logic [10:0] start_minute;
  } period_entry_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [10:0] now_minute;
    logic [2:0]  now_wday;
    logic [4:0]  now_mday;
    logic [3:0]  now_month;
    logic [7:0]  action_code;
    logic [10:0] start_minute;
    logic [7:0]  week_mask;
    logic [31:0] day_mask;
    logic [12:0] month_mask;
    logic [4:0]  plan_number;
    logic [5:0]  slot_index;
  } in_data_t;

  typedef struct packed {
    logic [2:0] pad;
    logic [4:0] chosen_plan;
    logic [7:0] chosen_action;
  } out_data_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCHED,
    ST_PERIOD,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/core/todpl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module todpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/time_of_day_plan_lookup.sv =====
// ----------------------------------------------------------------------------
// Time-of-day plan lookup
// Schedule and day-plan tables with a sequential query engine.
// ----------------------------------------------------------------------------
// After reset the block clears both tables and is not ready during that time.
// A write transfer leaves the block in the idle state. A query walks the
// schedule table one slot per cycle through its read port until a slot
// matches or the last slot is read, then on a match walks the 64 periods of
// the chosen plan one per cycle through the period table's read port, keeping
// the latest period at or before the query minute and the latest overall; the
// block takes no new transfer until the result is in the output register.
module time_of_day_plan_lookup
  import todpl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot_index, plan_number, month_mask, day_mask, week_mask, start_minute,
  // action_code, now_month, now_mday, now_wday, now_minute, zero padding
  input  logic [111:0] s_axis_tdata,
  // func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // chosen_action, chosen_plan, zero padding
  output logic [15:0]  m_axis_tdata
);

  in_data_t      in_data;
  sched_entry_t  s_rd;
  period_entry_t p_rd;
  logic [57:0]   sched_rdata;
  logic [18:0]   per_rdata;

  state_e state_q, state_d;
  logic [CLR_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   pidx_q, pidx_d;
  logic               pend_q, pend_d;
  logic [3:0]         month_q, month_d;
  logic [4:0]         mday_q, mday_d;
  logic [2:0]         wday_q, wday_d;
  logic [10:0]        minute_q, minute_d;
  logic [4:0]         plan_q, plan_d;
  logic [PADDR_W-1:0] base_q, base_d;
  logic               hb_q, hb_d, ha_q, ha_d;
  logic [10:0]        bb_q, bb_d, ba_q, ba_d;
  logic [7:0]         ab_q, ab_d, aa_q, aa_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_action_q, out_action_d;
  logic [4:0]         out_plan_q, out_plan_d;

  logic               sched_we, per_we;
  logic [SLOT_W-1:0]  sched_waddr, sched_raddr;
  logic [PADDR_W-1:0] per_waddr, per_raddr;
  sched_entry_t       sched_wdata;
  period_entry_t      per_wdata;

  logic               in_accept;
  logic               sched_hit;
  logic               scan_last;
  logic               out_free;
  logic [15:0]        month_ext;
  logic [2:0]         wbit;
  logic               plan_ok;
  out_data_t          out_data;

  assign in_data   = in_data_t'(s_axis_tdata);
  assign s_rd      = sched_entry_t'(sched_rdata);
  assign p_rd      = period_entry_t'(per_rdata);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  assign month_ext = 16'(s_rd.month_mask);
  assign wbit      = (wday_q == 3'd0) ? SUNDAY_BIT : wday_q;
  assign sched_hit = (month_ext[month_q] && s_rd.day_mask[mday_q]) || s_rd.week_mask[wbit];
  assign scan_last = (state_q == ST_SCHED) ?
                     (pidx_q == CNT_W'(SCHEDULE_SLOTS - 1)) :
                     (pidx_q == CNT_W'(PERIODS_PER_PLAN - 1));
  assign plan_ok   = (in_data.plan_number != 5'd0) &&
                     (in_data.plan_number <= 5'(PLAN_TABLES));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept && (s_axis_tuser == FUNC_QUERY)) begin
          state_d = ST_SCHED;
        end
      end
      ST_SCHED: begin
        if (pend_q && sched_hit) begin
          state_d = ST_PERIOD;
        end else if (pend_q && scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_PERIOD: begin
        if (pend_q && scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);

    sched_we    = 1'b0;
    sched_waddr = SLOT_W'(in_data.slot_index);
    sched_wdata = '{plan_number: in_data.plan_number, week_mask: in_data.week_mask,
                    day_mask: in_data.day_mask, month_mask: in_data.month_mask};
    per_we      = 1'b0;
    per_waddr   = PADDR_W'((int'(in_data.plan_number) - 1) * PERIODS_PER_PLAN
                           + int'(in_data.slot_index));
    per_wdata   = '{action_code: in_data.action_code, start_minute: in_data.start_minute};
    sched_raddr = cnt_q[SLOT_W-1:0];
    per_raddr   = base_q + PADDR_W'(cnt_q);

    clr_d        = clr_q;
    cnt_d        = cnt_q;
    pidx_d       = pidx_q;
    pend_d       = pend_q;
    month_d      = month_q;
    mday_d       = mday_q;
    wday_d       = wday_q;
    minute_d     = minute_q;
    plan_d       = plan_q;
    base_d       = base_q;
    hb_d         = hb_q;
    bb_d         = bb_q;
    ab_d         = ab_q;
    ha_d         = ha_q;
    ba_d         = ba_q;
    aa_d         = aa_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_action_d = out_action_q;
    out_plan_d   = out_plan_q;

    case (state_q)
      ST_CLEAR: begin
        sched_we    = (int'(clr_q) < SCHEDULE_SLOTS);
        sched_waddr = SLOT_W'(clr_q);
        sched_wdata = '0;
        per_we      = (int'(clr_q) < PERIOD_DEPTH);
        per_waddr   = PADDR_W'(clr_q);
        per_wdata   = '0;
        clr_d       = clr_q + CLR_W'(1);
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser)
            FUNC_WR_SCHED: begin
              sched_we = plan_ok && (int'(in_data.slot_index) < SCHEDULE_SLOTS);
            end
            FUNC_WR_PERIOD: begin
              per_we = plan_ok && (in_data.action_code != 8'd0) &&
                       (int'(in_data.slot_index) < PERIODS_PER_PLAN);
            end
            FUNC_QUERY: begin
              month_d  = in_data.now_month;
              mday_d   = in_data.now_mday;
              wday_d   = in_data.now_wday;
              minute_d = in_data.now_minute;
              cnt_d    = '0;
              pend_d   = 1'b0;
              plan_d   = 5'd0;
              hb_d     = 1'b0;
              ha_d     = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCHED: begin
        if (int'(cnt_q) < SCHEDULE_SLOTS) begin
          cnt_d  = cnt_q + CNT_W'(1);
          pidx_d = cnt_q;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && sched_hit) begin
          plan_d = s_rd.plan_number;
          base_d = PADDR_W'((int'(s_rd.plan_number) - 1) * PERIODS_PER_PLAN);
          cnt_d  = '0;
          pend_d = 1'b0;
        end
      end
      ST_PERIOD: begin
        if (int'(cnt_q) < PERIODS_PER_PLAN) begin
          cnt_d  = cnt_q + CNT_W'(1);
          pidx_d = cnt_q;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (p_rd.action_code != 8'd0)) begin
          if ((p_rd.start_minute <= minute_q) && (!hb_q || (p_rd.start_minute > bb_q))) begin
            hb_d = 1'b1;
            bb_d = p_rd.start_minute;
            ab_d = p_rd.action_code;
          end
          if (!ha_q || (p_rd.start_minute > ba_q)) begin
            ha_d = 1'b1;
            ba_d = p_rd.start_minute;
            aa_d = p_rd.action_code;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_plan_d   = plan_q;
          out_action_d = hb_q ? ab_q : (ha_q ? aa_q : 8'd0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    pidx_q       <= pidx_d;
    month_q      <= month_d;
    mday_q       <= mday_d;
    wday_q       <= wday_d;
    minute_q     <= minute_d;
    plan_q       <= plan_d;
    base_q       <= base_d;
    hb_q         <= hb_d;
    bb_q         <= bb_d;
    ab_q         <= ab_d;
    ha_q         <= ha_d;
    ba_q         <= ba_d;
    aa_q         <= aa_d;
    out_action_q <= out_action_d;
    out_plan_q   <= out_plan_d;
  end

  todpl_ram #(
    .WIDTH ($bits(sched_entry_t)),
    .DEPTH (SCHEDULE_SLOTS)
  ) u_sched_ram (
    .clk_i   (clk_i),
    .we_i    (sched_we),
    .waddr_i (sched_waddr),
    .wdata_i (sched_wdata),
    .raddr_i (sched_raddr),
    .rdata_o (sched_rdata)
  );

  todpl_ram #(
    .WIDTH ($bits(period_entry_t)),
    .DEPTH (PERIOD_DEPTH)
  ) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (per_we),
    .waddr_i (per_waddr),
    .wdata_i (per_wdata),
    .raddr_i (per_raddr),
    .rdata_o (per_rdata)
  );

  always_comb begin
    out_data               = '0;
    out_data.chosen_action = out_action_q;
    out_data.chosen_plan   = out_plan_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Time-of-day plan lookup testbench
// Fills the schedule and period tables through the input stream and checks
// every lookup result against a model of both tables that the bench keeps
// itself. Directed tests cover empty tables, calendar and weekday matching,
// period choice with ties and the wrap to the previous day, and ignored
// transfers; random traffic with random idling on both sides follows.
// ----------------------------------------------------------------------------
module tb_top
  import todpl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 140;
  localparam int RANDOM_ITEMS   = 1700;

  typedef struct packed {
    logic [4:0] plan;
    logic [7:0] action;
  } lookup_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = FUNC_UNUSED;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;

  sched_entry_t   sched_mirror [SCHEDULE_SLOTS];
  period_entry_t  period_mirror [PERIOD_DEPTH];
  lookup_result_t lookups_pending [$];

  int         failures = 0;
  int         results_checked = 0;
  int         queries_sent = 0;
  int         sched_writes = 0;
  int         period_writes = 0;
  int         hits_with_action = 0;
  int         hits_empty_plan = 0;
  int         no_slot_matched = 0;
  int         idle_cycles = 0;
  int         rx_wait = 0;
  bit         quiet_phase = 1'b0;
  logic [10:0] last_start = '0;
  out_data_t  got;
  lookup_result_t want;

  time_of_day_plan_lookup uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5ns clk_i = ~clk_i;

  function automatic lookup_result_t predict_lookup(input in_data_t d);
    lookup_result_t r;
    int             wbit;
    int             base;
    bit             have_before;
    bit             have_any;
    logic [10:0]    best_before;
    logic [10:0]    best_any;
    logic [7:0]     act_before;
    logic [7:0]     act_any;
    period_entry_t  p;
    r = '0;
    have_before = 1'b0;
    have_any = 1'b0;
    best_before = '0;
    best_any = '0;
    act_before = '0;
    act_any = '0;
    wbit = (d.now_wday == 3'd0) ? int'(SUNDAY_BIT) : int'(d.now_wday);
    for (int s = 0; s < SCHEDULE_SLOTS; s++) begin
      if ((((32'(sched_mirror[s].month_mask) >> d.now_month) & 32'd1) != 0 &&
           ((sched_mirror[s].day_mask >> d.now_mday) & 32'd1) != 0) ||
          ((32'(sched_mirror[s].week_mask) >> wbit) & 32'd1) != 0) begin
        r.plan = sched_mirror[s].plan_number;
        break;
      end
    end
    if (r.plan != 0 && r.plan <= PLAN_TABLES) begin
      base = (int'(r.plan) - 1) * PERIODS_PER_PLAN;
      for (int i = 0; i < PERIODS_PER_PLAN; i++) begin
        p = period_mirror[base + i];
        if (p.action_code != 0) begin
          if (p.start_minute <= d.now_minute &&
              (!have_before || p.start_minute > best_before)) begin
            have_before = 1'b1;
            best_before = p.start_minute;
            act_before = p.action_code;
          end
          if (!have_any || p.start_minute > best_any) begin
            have_any = 1'b1;
            best_any = p.start_minute;
            act_any = p.action_code;
          end
        end
      end
      r.action = have_before ? act_before : (have_any ? act_any : 8'd0);
    end
    return r;
  endfunction

  task automatic absorb_transfer(input logic [1:0] func, input in_data_t d);
    lookup_result_t r;
    case (func)
      FUNC_WR_SCHED: begin
        sched_writes++;
        if (d.plan_number != 0 && d.plan_number <= PLAN_TABLES &&
            d.slot_index < SCHEDULE_SLOTS) begin
          sched_mirror[d.slot_index].month_mask = d.month_mask;
          sched_mirror[d.slot_index].day_mask = d.day_mask;
          sched_mirror[d.slot_index].week_mask = d.week_mask;
          sched_mirror[d.slot_index].plan_number = d.plan_number;
        end
      end
      FUNC_WR_PERIOD: begin
        period_writes++;
        if (d.action_code != 0 && d.plan_number != 0 && d.plan_number <= PLAN_TABLES &&
            d.slot_index < PERIODS_PER_PLAN) begin
          period_mirror[(int'(d.plan_number) - 1) * PERIODS_PER_PLAN + int'(d.slot_index)] =
            '{action_code: d.action_code, start_minute: d.start_minute};
        end
      end
      FUNC_QUERY: begin
        queries_sent++;
        r = predict_lookup(d);
        lookups_pending.push_back(r);
        if (r.plan == 0) begin
          no_slot_matched++;
        end else if (r.action == 0) begin
          hits_empty_plan++;
        end else begin
          hits_with_action++;
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic in_data_t random_filler();
    logic [127:0] raw;
    in_data_t     d;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    d = raw[111:0];
    d.pad = '0;
    return d;
  endfunction

  task automatic send_item(input logic [1:0] func, input in_data_t d);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    absorb_transfer(func, d);
  endtask

  task automatic send_sched(input int slot, input int plan, input logic [12:0] month,
                            input logic [31:0] day, input logic [7:0] week);
    in_data_t d;
    d = random_filler();
    d.slot_index = 6'(slot);
    d.plan_number = 5'(plan);
    d.month_mask = month;
    d.day_mask = day;
    d.week_mask = week;
    send_item(FUNC_WR_SCHED, d);
  endtask

  task automatic send_period(input int slot, input int plan, input int start,
                             input int action);
    in_data_t d;
    d = random_filler();
    d.slot_index = 6'(slot);
    d.plan_number = 5'(plan);
    d.start_minute = 11'(start);
    d.action_code = 8'(action);
    send_item(FUNC_WR_PERIOD, d);
  endtask

  task automatic send_query(input int month, input int mday, input int wday,
                            input int minute);
    in_data_t d;
    d = random_filler();
    d.now_month = 4'(month);
    d.now_mday = 5'(mday);
    d.now_wday = 3'(wday);
    d.now_minute = 11'(minute);
    send_item(FUNC_QUERY, d);
  endtask

  task automatic test_empty_tables();
    send_query(1, 1, 0, 0);
    send_query(12, 31, 6, 1439);
  endtask

  task automatic test_schedule_match();
    send_sched(5, 3, '0, '0, 8'h80);
    send_query(6, 15, 0, 0);
    send_query(6, 15, 7, 0);
    send_sched(2, 2, 13'h1000, 32'h8000_0000, '0);
    send_query(12, 31, 1, 0);
    send_query(13, 31, 1, 0);
    send_sched(63, 16, '1, '1, '1);
    send_query(1, 1, 3, 0);
  endtask

  task automatic test_period_choice();
    send_period(0, 2, 1439, 255);
    send_period(1, 2, 600, 1);
    send_period(2, 2, 600, 9);
    send_period(63, 2, 2047, 77);
    send_query(12, 31, 1, 1439);
    send_query(12, 31, 1, 700);
    send_query(12, 31, 1, 50);
    send_query(12, 31, 1, 2047);
  endtask

  task automatic test_ignored_items();
    send_sched(0, 0, '1, '1, '1);
    send_sched(1, 17, '1, '1, '1);
    send_period(3, 2, 800, 0);
    send_period(4, 0, 800, 5);
    send_period(5, 31, 800, 5);
    send_item(FUNC_UNUSED, random_filler());
    send_query(12, 31, 1, 900);
    send_query(1, 1, 3, 0);
  endtask

  function automatic int random_plan();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 0;
    if (pick < 10) return $urandom_range(17, 31);
    if (pick < 75) return $urandom_range(1, 4);
    return $urandom_range(1, PLAN_TABLES);
  endfunction

  task automatic test_random_traffic();
    int pick;
    int start;
    int minute;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) quiet_phase = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_sched(($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 63),
                   random_plan(), 13'($urandom() & $urandom()), $urandom() & $urandom(),
                   8'($urandom() & $urandom() & $urandom()));
      end else if (pick < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) start = ($urandom_range(0, 1) != 0) ? 1439 : 0;
        else if (pick < 15) start = $urandom_range(1440, 2047);
        else start = $urandom_range(0, 1439);
        last_start = 11'(start);
        send_period($urandom_range(0, 63), random_plan(), start,
                    ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 255));
      end else if (pick < 95) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) minute = last_start;
        else if (pick < 20) minute = $urandom_range(1440, 2047);
        else if (pick < 25) minute = ($urandom_range(0, 1) != 0) ? 1439 : 0;
        else minute = $urandom_range(0, 1439);
        send_query(($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 15),
                   ($urandom_range(0, 9) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 31),
                   ($urandom_range(0, 9) != 0) ? $urandom_range(0, 6) : 7,
                   minute);
      end else begin
        send_item(FUNC_UNUSED, random_filler());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (lookups_pending.size() == 0) begin
        $error("Unexpected result: chosen_action %0d, chosen_plan %0d",
               got.chosen_action, got.chosen_plan);
        failures++;
      end else begin
        want = lookups_pending.pop_front();
        results_checked++;
        if (got.chosen_action !== want.action) begin
          $error("chosen_action: expected %0d, got %0d", want.action, got.chosen_action);
          failures++;
        end
        if (got.chosen_plan !== want.plan) begin
          $error("chosen_plan: expected %0d, got %0d", want.plan, got.chosen_plan);
          failures++;
        end
      end
      rx_wait = quiet_phase ? 0 : $urandom_range(0, 3);
    end
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SCHEDULE_SLOTS; s++) sched_mirror[s] = '0;
    for (int p = 0; p < PERIOD_DEPTH; p++) period_mirror[p] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tables();
    test_schedule_match();
    test_period_choice();
    test_ignored_items();
    test_random_traffic();

    s_axis_tvalid <= 1'b0;
    while (lookups_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d lookups, %0d schedule writes and %0d period writes; %0d results checked.",
             queries_sent, sched_writes, period_writes, results_checked);
    $display("Lookups: %0d found an action, %0d hit an empty plan, %0d matched no slot.",
             hits_with_action, hits_empty_plan, no_slot_matched);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/todpl_pkg.sv
rtl/core/todpl_ram.sv
rtl/core/time_of_day_plan_lookup.sv
bench/tb_top.sv
